[hdl/sha256_pkg.sv]
// SHA-256 package: constants, state enum and round helper functions.
// No dependencies.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } hs_state_t;

  localparam int BlockBytes = 64;
  localparam int LenPos     = 56;
  localparam int Rounds     = 64;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic CmdAbsorb = 1'b0;
  localparam logic CmdFinish = 1'b1;

  localparam logic [31:0] InitValue [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[hdl/sha256_byte_stream_hasher.sv]
// An absorb transfer writes one byte; the 64th byte of a block starts a
// compression: buffer load, rounds and fold on one shared round unit.
// A finish transfer pads (one byte a cycle), runs one or two compressions,
// then presents 8 digest words, one a cycle while out_tready is high.
// rst_n (synchronous, active low) restores the initial hash and zero count.
// Depends on sha256_pkg.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);
  import sha256_pkg::*;

  hs_state_t state_r, state_nxt;

  // block buffer memory, one byte write and one word read per cycle
  logic [31:0] buf_mem [BlockBytes / 4];
  logic [31:0] rd_word_r;

  logic [31:0] hv_r [8];
  logic [31:0] wk_r [16];         // message schedule window
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [63:0] count_r;
  logic [5:0]  pad_pos_r;         // byte being padded
  logic        finishing_r;       // compression belongs to a finish
  logic        len_pending_r;     // second padding block still needed
  logic [6:0]  step_r;            // load/round counter
  logic [2:0]  emit_idx_r;

  logic        in_xfer, out_xfer;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic        wr_en;
  logic [3:0]  rd_addr;
  logic [31:0] w_cur, w_new, t1, t2;
  logic [63:0] bits;
  logic [2:0]  len_sel;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign bits     = {count_r[60:0], 3'b000};
  assign len_sel  = pad_pos_r[2:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == CmdFinish) begin
            // marker filled the block: compress it as is
            state_nxt = (count_r[5:0] == 6'd63) ? ST_LOAD : ST_PAD;
          end else if (count_r[5:0] == 6'd63) state_nxt = ST_LOAD;
        end
      end
      ST_PAD: begin
        if (pad_pos_r == 6'd63) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (step_r == 7'd16) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (step_r == 7'(Rounds - 1)) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        if (!finishing_r) state_nxt = ST_IDLE;
        else if (len_pending_r) state_nxt = ST_PAD;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer && emit_idx_r == 3'd7) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and buffer write selection
  always_comb begin
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    wr_en = 1'b0;
    wr_addr = pad_pos_r;
    wr_data = 8'h00;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        wr_addr = count_r[5:0];
        wr_data = (in_tuser == CmdFinish) ? PadMark : in_tdata;
        wr_en = in_xfer;
      end
      ST_PAD: begin
        wr_en = 1'b1;
        if (!len_pending_r && pad_pos_r >= 6'(LenPos))
          wr_data = bits[63 - 8 * len_sel -: 8];
      end
      ST_EMIT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign out_tdata = hv_r[emit_idx_r];
  assign out_tuser = emit_idx_r;
  assign out_tlast = (emit_idx_r == 3'd7);

  // buffer memory, big-endian bytes within each word
  assign rd_addr = step_r[3:0];
  always_ff @(posedge clk) begin
    if (wr_en) buf_mem[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    rd_word_r <= buf_mem[rd_addr];
  end

  // shared round unit
  assign w_new = wk_r[0] + sml_sig0(wk_r[1]) + wk_r[9] + sml_sig1(wk_r[14]);
  assign w_cur = (step_r < 7'd16) ? wk_r[step_r[3:0]] : w_new;
  assign t1 = h_r + big_sig1(e_r) + ((e_r & f_r) ^ (~e_r & g_r))
              + RoundK[step_r[5:0]] + w_cur;
  assign t2 = big_sig0(a_r) + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pad_pos_r <= '0;
      finishing_r <= 1'b0;
      len_pending_r <= 1'b0;
      step_r <= '0;
      emit_idx_r <= '0;
      for (int i = 0; i < 8; i++) hv_r[i] <= InitValue[i];
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          step_r <= '0;
          emit_idx_r <= '0;
          if (in_xfer) begin
            if (in_tuser == CmdFinish) begin
              finishing_r <= 1'b1;
              pad_pos_r <= count_r[5:0] + 6'd1;
              len_pending_r <= (count_r[5:0] >= 6'(LenPos));
            end else begin
              finishing_r <= 1'b0;
              count_r <= count_r + 64'd1;
            end
          end
        end
        ST_PAD: begin
          pad_pos_r <= pad_pos_r + 6'd1;
          step_r <= '0;
        end
        ST_LOAD: begin
          step_r <= (step_r == 7'd16) ? 7'd0 : step_r + 7'd1;
          if (step_r != 7'd0) wk_r[step_r[3:0] - 4'd1] <= rd_word_r;
          a_r <= hv_r[0]; b_r <= hv_r[1]; c_r <= hv_r[2]; d_r <= hv_r[3];
          e_r <= hv_r[4]; f_r <= hv_r[5]; g_r <= hv_r[6]; h_r <= hv_r[7];
        end
        ST_ROUND: begin
          step_r <= step_r + 7'd1;
          if (step_r >= 7'd16) begin
            for (int i = 0; i < 15; i++) wk_r[i] <= wk_r[i + 1];
            wk_r[15] <= w_new;
          end else begin
            for (int i = 0; i < 16; i++) wk_r[i] <= wk_r[i];
          end
          h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
          d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
        end
        ST_FOLD: begin
          hv_r[0] <= hv_r[0] + a_r; hv_r[1] <= hv_r[1] + b_r;
          hv_r[2] <= hv_r[2] + c_r; hv_r[3] <= hv_r[3] + d_r;
          hv_r[4] <= hv_r[4] + e_r; hv_r[5] <= hv_r[5] + f_r;
          hv_r[6] <= hv_r[6] + g_r; hv_r[7] <= hv_r[7] + h_r;
          step_r <= '0;
          if (finishing_r && len_pending_r) begin
            len_pending_r <= 1'b0;
            pad_pos_r <= '0;
          end
        end
        ST_EMIT: begin
          if (out_xfer) begin
            emit_idx_r <= emit_idx_r + 3'd1;
            if (emit_idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) hv_r[i] <= InitValue[i];
              count_r <= '0;
              finishing_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // words leave in order 0..7; the last one carries tlast by its assign
  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && emit_idx_r != 3'd7 |=> emit_idx_r == $past(emit_idx_r) + 3'd1)
    else $error("digest word order broken");
  // no input taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest pending");
  // the finish clears the byte count after the last word
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_tlast |=> count_r == 64'd0)
    else $error("byte count not cleared");
`endif

endmodule

[tb/tb_sha256_byte_stream_hasher.sv]
// Testbench for sha256_byte_stream_hasher: byte messages in, digest words out,
// checked against a behavioral SHA-256 predictor kept in this file.
// Depends on sha256_pkg and the hasher RTL.
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher;
  import sha256_pkg::*;

  localparam int StallLimit = 20000;
  localparam int ItemTarget = 280;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  logic [63:0] msg_bytes;

  digest_word_t digest_q [$];
  int          error_cnt;
  int          bytes_sent;
  int          digests_sent;
  int          words_seen;
  int          idle_cycles;

  sha256_byte_stream_hasher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one SHA-256 compression over msg_block
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    w = '{default: '0};
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + RoundK[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = InitValue[i];
    msg_bytes = '0;
  endfunction

  // predictor update for one accepted transfer; a finish yields the expected digest words
  function automatic void predict_transfer(logic cmd, logic [7:0] data);
    int pos;
    logic [63:0] bit_len;
    digest_word_t dw;
    pos = int'(msg_bytes[5:0]);
    if (cmd == CmdAbsorb) begin
      msg_block[pos] = data;
      msg_bytes++;
      if (pos == BlockBytes - 1) compress_block();
      return;
    end
    msg_block[pos] = PadMark;
    pos++;
    if (pos > LenPos) begin
      for (int i = pos; i < BlockBytes; i++) msg_block[i] = 8'h00;
      compress_block();
      for (int i = 0; i < LenPos; i++) msg_block[i] = 8'h00;
    end else begin
      for (int i = pos; i < LenPos; i++) msg_block[i] = 8'h00;
    end
    bit_len = msg_bytes << 3;
    for (int i = 0; i < 8; i++) msg_block[LenPos + i] = bit_len[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      dw.word = hash_state[i];
      dw.idx  = 3'(i);
      dw.last = (i == 7);
      digest_q.push_back(dw);
    end
    restart_hash();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_val, $realtime);
    error_cnt++;
  endtask

  function automatic int rand_gap();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // drive one transfer, wait for acceptance, predict on acceptance
  task automatic send_item(logic cmd, logic [7:0] data, bit allow_gap = 1);
    int gap;
    gap = allow_gap ? rand_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    predict_transfer(cmd, data);
    if (cmd == CmdAbsorb) bytes_sent++; else digests_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit allow_gap = 1);
    for (int i = 0; i < len; i++) send_item(CmdAbsorb, 8'($urandom), allow_gap);
    send_item(CmdFinish, 8'($urandom), allow_gap);
  endtask

  // result side: random ready, compare each accepted word
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(9) < 7);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (digest_q.size() == 0) begin
        $display("unexpected digest word %h at %0t", out_tdata, $realtime);
        error_cnt++;
      end else begin
        digest_word_t exp_dw;
        exp_dw = digest_q.pop_front();
        if (out_tdata !== exp_dw.word) report_mismatch("digest_word", out_tdata, exp_dw.word);
        if (out_tuser !== exp_dw.idx)
          report_mismatch("word_index", 32'(out_tuser), 32'(exp_dw.idx));
        if (out_tlast !== exp_dw.last)
          report_mismatch("last_word", 32'(out_tlast), 32'(exp_dw.last));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", StallLimit);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_empty_message();
    send_item(CmdFinish, 8'hFF);
    send_item(CmdFinish, 8'h00);
  endtask

  // single bytes at the field extremes and each bit alone
  task automatic test_byte_extremes();
    send_item(CmdAbsorb, 8'h00); send_item(CmdFinish, 8'h00);
    send_item(CmdAbsorb, 8'hFF); send_item(CmdFinish, 8'hFF);
    for (int i = 0; i < 8; i++) send_item(CmdAbsorb, 8'(1 << i));
    send_item(CmdFinish, 8'h5A);
  endtask

  // 55/56 pending bytes straddle the extra padding block; 64 fills exactly
  task automatic test_padding_boundaries();
    send_message(55, 0);
    send_message(56, 0);
    send_message(64);
  endtask

  task automatic test_random_messages();
    int len;
    int room;
    while (bytes_sent + digests_sent < ItemTarget) begin
      case ($urandom_range(3))
        0: len = $urandom_range(3);
        1: len = $urandom_range(54, 57);
        2: len = $urandom_range(62, 66);
        default: len = $urandom_range(130);
      endcase
      // keep the total near the item budget
      room = ItemTarget - 1 - (bytes_sent + digests_sent);
      if (len > room) len = room;
      send_message(len);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    bytes_sent = 0; digests_sent = 0;
    restart_hash();
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CmdAbsorb;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_message();
    test_byte_extremes();
    test_padding_boundaries();
    test_random_messages();
    drain_results();

    $display("covered %0d message bytes and %0d digests (%0d words checked)",
             bytes_sent, digests_sent, words_seen);
    $display("including empty messages and padding at 55, 56 and 64 pending bytes");
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
